@@ rtl/core/chi_square_edge_score_top_assert.svh @@
// Assertion macros shared by the chi-square edge score RTL.
`ifndef CHI_SQUARE_EDGE_SCORE_TOP_ASSERT_SVH
`define CHI_SQUARE_EDGE_SCORE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSES_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CSES_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ rtl/core/cses_pkg.sv @@
// Shared types and constants of the chi-square edge score block.
`timescale 1ns / 1ps
package cses_pkg;
	localparam int SCORE_BITS = 40;
	localparam int REG_IDX_BITS = 2;

	localparam logic [REG_IDX_BITS-1:0] REG_DOC_TOTAL = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_JOINT = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 2'd2;

	// Outcome class of a pair as it travels down the pipe.
	typedef enum logic [1:0] {
		CLS_CALC = 2'd0,
		CLS_DROP = 2'd1,
		CLS_SAT  = 2'd2
	} cls_t;

	typedef struct packed {
		logic valid;
		cls_t cls;
	} cs_ctl_t;
endpackage

@@ rtl/core/cses_front.sv @@
// Front pipeline: contingency terms, squared numerator, denominator, overflow check.
`timescale 1ns / 1ps
module cses_front import cses_pkg::*; #(
	parameter int COUNT_BITS = 24,
	parameter int FRAC_BITS = 16,
	parameter int RW = 4 * COUNT_BITS + SCORE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [COUNT_BITS-1:0] joint_count,
	input  logic [COUNT_BITS-1:0] count_first,
	input  logic [COUNT_BITS-1:0] count_second,
	input  logic [COUNT_BITS-1:0] doc_total,
	input  logic [COUNT_BITS-1:0] min_joint,
	output cs_ctl_t               ctl_out,
	output logic [RW-1:0]         rem_out,
	output logic [4*COUNT_BITS-1:0] den_out
);
	localparam int C = COUNT_BITS;
	localparam int W2 = 2 * C;
	localparam int W4 = 4 * C;
	localparam int NW = 5 * C + FRAC_BITS;
	localparam int BW = (NW > RW) ? NW : RW;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [W2-1:0] p_s1, q_s1;
	logic [C-1:0]  d1_s1, d2_s1;
	logic          mf_s1, zd_s1, ng_s1, nz_s1;
	logic [W2-1:0] a_s2, r_s2, q_s2;
	cls_t          cls_s2, cls_s3, cls_s4, cls_s5, cls_s6, cls_s7;
	logic [W2-1:0] hh_s3, hl_s3, ll_s3, qhrh_s3, qhrl_s3, qlrh_s3, qlrl_s3;
	logic [W4-1:0] a2_s4, den_s4, den_s5, den_s6, den_s7;
	logic [W2-1:0] m_s5 [4];
	logic [NW-1:0] num_s6, nsum;
	logic [RW-1:0] rem_s7;
	logic [BW-1:0] numx;
	logic          big;

	always_comb begin
		nsum = '0;
		for (int k = 0; k < 4; k++) begin
			nsum = nsum + (NW'(m_s5[k]) << (k * C));
		end
		numx = BW'(num_s6);
		big = numx >= (BW'(den_s6) << SCORE_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: joint and marginal products, margin complements, flags
			p_s1  <= W2'(joint_count) * W2'(doc_total);
			q_s1  <= W2'(count_first) * W2'(count_second);
			d1_s1 <= (doc_total >= count_first) ? doc_total - count_first
			                                    : count_first - doc_total;
			d2_s1 <= (doc_total >= count_second) ? doc_total - count_second
			                                     : count_second - doc_total;
			mf_s1 <= joint_count < min_joint;
			nz_s1 <= doc_total == '0;
			zd_s1 <= (count_first == '0) || (count_second == '0) ||
			         (count_first == doc_total) || (count_second == doc_total);
			ng_s1 <= (count_first > doc_total) != (count_second > doc_total);
			// s2: numerator term and complement product, classify
			a_s2 <= (p_s1 >= q_s1) ? p_s1 - q_s1 : q_s1 - p_s1;
			r_s2 <= W2'(d1_s1) * W2'(d2_s1);
			q_s2 <= q_s1;
			if (mf_s1 || nz_s1 || (p_s1 == q_s1)) cls_s2 <= CLS_DROP;
			else if (zd_s1) cls_s2 <= CLS_SAT;
			else if (ng_s1) cls_s2 <= CLS_DROP;
			else cls_s2 <= CLS_CALC;
			// s3: partial products of the square and of the denominator
			hh_s3   <= W2'(a_s2[W2-1:C]) * W2'(a_s2[W2-1:C]);
			hl_s3   <= W2'(a_s2[W2-1:C]) * W2'(a_s2[C-1:0]);
			ll_s3   <= W2'(a_s2[C-1:0]) * W2'(a_s2[C-1:0]);
			qhrh_s3 <= W2'(q_s2[W2-1:C]) * W2'(r_s2[W2-1:C]);
			qhrl_s3 <= W2'(q_s2[W2-1:C]) * W2'(r_s2[C-1:0]);
			qlrh_s3 <= W2'(q_s2[C-1:0]) * W2'(r_s2[W2-1:C]);
			qlrl_s3 <= W2'(q_s2[C-1:0]) * W2'(r_s2[C-1:0]);
			cls_s3  <= cls_s2;
			// s4: sum partial products
			a2_s4  <= (W4'(hh_s3) << W2) + (W4'(hl_s3) << (C + 1)) + W4'(ll_s3);
			den_s4 <= (W4'(qhrh_s3) << W2) + (W4'(qhrl_s3) << C) +
			          (W4'(qlrh_s3) << C) + W4'(qlrl_s3);
			cls_s4 <= cls_s3;
			// s5: square times N, one chunk per multiplier
			for (int k = 0; k < 4; k++) begin
				m_s5[k] <= W2'(a2_s4[k*C +: C]) * W2'(doc_total);
			end
			den_s5 <= den_s4;
			cls_s5 <= cls_s4;
			// s6: assemble scaled numerator
			num_s6 <= nsum << FRAC_BITS;
			den_s6 <= den_s5;
			cls_s6 <= cls_s5;
			// s7: quotient overflow check
			rem_s7 <= numx[RW-1:0];
			den_s7 <= den_s6;
			cls_s7 <= (cls_s6 == CLS_CALC && big) ? CLS_SAT : cls_s6;
		end
	end

	assign ctl_out = '{valid: v_s7, cls: cls_s7};
	assign rem_out = rem_s7;
	assign den_out = den_s7;
endmodule

@@ rtl/core/cses_div_cell.sv @@
// One restoring division cell: resolves a single quotient bit.
`timescale 1ns / 1ps
module cses_div_cell import cses_pkg::*; #(
	parameter int DW = 96,
	parameter int RW = 136,
	parameter int STEP = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  cs_ctl_t               ctl_in,
	input  logic [RW-1:0]         rem_in,
	input  logic [DW-1:0]         den_in,
	input  logic [SCORE_BITS-1:0] quot_in,
	output cs_ctl_t               ctl_out,
	output logic [RW-1:0]         rem_out,
	output logic [DW-1:0]         den_out,
	output logic [SCORE_BITS-1:0] quot_out
);
	logic [RW-1:0] sh;
	logic          ge;

	assign sh = RW'(den_in) << STEP;
	assign ge = rem_in >= sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '{valid: 1'b0, cls: CLS_CALC};
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= ge ? rem_in - sh : rem_in;
			den_out  <= den_in;
			quot_out <= quot_in | (ge ? (SCORE_BITS'(1) << STEP) : '0);
		end
	end
endmodule

@@ rtl/core/chi_square_edge_score_top.sv @@
// Top level of the chi-square edge score block: registers, pipe, division chain, output.
`timescale 1ns / 1ps
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  input     | in_valid / in_stall    | joint_count, count_first, count_second
//  output    | out_valid / out_stall  | score, keep, saturated
//  config    | wr_en                  | wr_index, wr_data
//
//  One pair per cycle while in_stall is low. A pair passes through seven front
//  stages (products, square, times N, overflow compare), forty division cells
//  that each settle one quotient bit, and the output register.
//  Reset clears the configuration registers to zero and empties every stage.
//  in_stall rises only when the skid beat is occupied; the whole pipe then
//  holds until the output beat is taken.
//  Write configuration only while no beat is in flight.
module chi_square_edge_score_top import cses_pkg::*; #(
	parameter int COUNT_BITS = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COUNT_BITS-1:0]   joint_count,
	input  logic [COUNT_BITS-1:0]   count_first,
	input  logic [COUNT_BITS-1:0]   count_second,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SCORE_BITS-1:0]   score,
	output logic                    keep,
	output logic                    saturated,
	input  logic                    wr_en,
	input  logic [REG_IDX_BITS-1:0] wr_index,
	input  logic [SCORE_BITS-1:0]   wr_data
);
	`include "chi_square_edge_score_top_assert.svh"

	localparam int DW = 4 * COUNT_BITS;
	localparam int RW = DW + SCORE_BITS;

	logic [COUNT_BITS-1:0] doc_total_q, min_joint_q;
	logic [SCORE_BITS-1:0] threshold_q;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_total_q <= '0;
			min_joint_q <= '0;
			threshold_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_DOC_TOTAL: doc_total_q <= wr_data[COUNT_BITS-1:0];
				REG_MIN_JOINT: min_joint_q <= wr_data[COUNT_BITS-1:0];
				REG_THRESHOLD: threshold_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic sk_v_q, out_v_q;

	// Advance the whole pipe whenever the skid beat is free.
	assign en = !sk_v_q;
	assign in_stall = sk_v_q;

	cs_ctl_t               ctl_c  [SCORE_BITS+1];
	logic [RW-1:0]         rem_c  [SCORE_BITS+1];
	logic [DW-1:0]         den_c  [SCORE_BITS+1];
	logic [SCORE_BITS-1:0] quot_c [SCORE_BITS+1];

	cses_front #(
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS(FRAC_BITS),
		.RW(RW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.joint_count(joint_count),
		.count_first(count_first),
		.count_second(count_second),
		.doc_total(doc_total_q),
		.min_joint(min_joint_q),
		.ctl_out(ctl_c[0]),
		.rem_out(rem_c[0]),
		.den_out(den_c[0])
	);
	assign quot_c[0] = '0;

	// Division chain, most significant quotient bit first.
	for (genvar j = 0; j < SCORE_BITS; j++) begin : g_div
		cses_div_cell #(
			.DW(DW),
			.RW(RW),
			.STEP(SCORE_BITS - 1 - j)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.ctl_in(ctl_c[j]),
			.rem_in(rem_c[j]),
			.den_in(den_c[j]),
			.quot_in(quot_c[j]),
			.ctl_out(ctl_c[j+1]),
			.rem_out(rem_c[j+1]),
			.den_out(den_c[j+1]),
			.quot_out(quot_c[j+1])
		);
	end

	// Final decision on the finished quotient.
	cs_ctl_t               fin;
	logic [SCORE_BITS-1:0] r_score;
	logic                  r_keep, r_sat;

	assign fin = ctl_c[SCORE_BITS];

	always_comb begin
		r_score = '0;
		r_keep  = 1'b0;
		r_sat   = 1'b0;
		case (fin.cls)
			CLS_SAT: begin
				r_score = '1;
				r_keep  = 1'b1;
				r_sat   = 1'b1;
			end
			CLS_CALC: begin
				if (quot_c[SCORE_BITS] > threshold_q) begin
					r_score = quot_c[SCORE_BITS];
					r_keep  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register plus one skid beat.
	logic [SCORE_BITS-1:0] out_score_q, sk_score_q;
	logic                  out_keep_q, out_sat_q, sk_keep_q, sk_sat_q;
	logic                  take;

	assign take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (take) sk_v_q <= 1'b0;
		end else if (fin.valid) begin
			if (out_v_q && !take) sk_v_q <= 1'b1;
			out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (take) begin
				out_score_q <= sk_score_q;
				out_keep_q  <= sk_keep_q;
				out_sat_q   <= sk_sat_q;
			end
		end else if (fin.valid) begin
			if (!out_v_q || take) begin
				out_score_q <= r_score;
				out_keep_q  <= r_keep;
				out_sat_q   <= r_sat;
			end else begin
				sk_score_q <= r_score;
				sk_keep_q  <= r_keep;
				sk_sat_q   <= r_sat;
			end
		end
	end

	assign out_valid = out_v_q;
	assign score     = out_score_q;
	assign keep      = out_keep_q;
	assign saturated = out_sat_q;

	`CSES_ASSERT_IMP(a_skid_behind_out, sk_v_q, out_v_q)
	`CSES_ASSERT_NEXT(a_skid_drains, sk_v_q && !out_stall, !sk_v_q)
	`CSES_ASSERT_IMP(a_sat_keeps, out_v_q && out_sat_q, out_keep_q && (out_score_q == '1))
	`CSES_ASSERT_IMP(a_drop_zero, out_v_q && !out_keep_q, out_score_q == '0)
endmodule
